@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define SKS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// expr must never be true outside reset
`define SKS_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`else

`define SKS_ASSERT(lbl, clk, rst, prop, msg)
`define SKS_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

@@ src/sks_pkg.sv @@
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types and register map constants of the k-th smallest selector.
// ----------------------------------------------------------------------------
package sks_pkg;

   // register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int RANK_BITS     = 7;

   localparam logic [RANK_BITS-1:0] RANK_RESET    = 7'd1;
   // word index of rank_k (paddr[2])
   localparam logic [0:0]           CSR_IDX_RANK_K = 1'b0;

   // per-cycle commands broadcast to every cell
   typedef struct packed {
      logic load;    // insert the incoming word
      logic drop;    // the top kept entry falls off after the insert
      logic drain;   // shift everything one cell toward cell 0
      logic clear;   // empty the store
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_ACCEPT = 2'b01,
      ST_DRAIN  = 2'b10
   } sel_state_type;

endpackage

@@ src/sks_cell.sv @@
// ----------------------------------------------------------------------------
// sks_cell
// One slot of the sorted insertion chain: holds a value and its valid flag,
// compares against the incoming word and shifts up or down with neighbors.
// ----------------------------------------------------------------------------
module sks_cell #(
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sks_pkg::cell_ctrl_type       ctrl,
   input  logic signed [VALUE_BITS-1:0] sample_value,
   input  logic signed [VALUE_BITS-1:0] left_value,
   input  logic                         left_valid,
   input  logic                         left_gt,
   input  logic signed [VALUE_BITS-1:0] right_value,
   input  logic                         right_valid,
   input  logic                         after_right,
   output logic signed [VALUE_BITS-1:0] value,
   output logic                         valid,
   output logic                         gt
);
   import sks_pkg::*;

   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic                         valid_ff, valid_in;

   assign gt    = valid_ff && (value_ff > sample_value);
   assign value = value_ff;
   assign valid = valid_ff;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.drain) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (ctrl.load) begin
         // larger entries move up one slot; the new word lands at the boundary
         if (left_gt) begin
            value_in = left_value;
         end else if (gt || !valid_ff) begin
            value_in = sample_value;
         end
         // occupancy grows by one, up to the depth; the new top slot goes if over rank
         valid_in = left_valid && !(ctrl.drop && !after_right);
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

@@ src/streaming_kth_smallest_selector.sv @@
// ----------------------------------------------------------------------------
// streaming_kth_smallest_selector
// Keeps the rank_k smallest words of a set in a sorted chain of cells and
// reports the largest kept word once the last word of the set is absorbed.
// ----------------------------------------------------------------------------
//  channel  | ports                               | moves
//  ---------+-------------------------------------+--------------------------
//  req      | req_valid/ready, sample, last_item  | one set element per word
//  rsp      | rsp_valid/ready, kth_value          | one word per finished set
//  csr      | APB psel/penable/pwrite/paddr/...   | rank_k at byte address 0
//
//  A non-last word is taken every cycle: all MAX_RANK cells compare against
//  it in parallel and shift together.
//  After a last word the chain drains toward cell 0 until only cell 0
//  holds a word (the largest kept); the result is then loaded into the
//  rsp output register once that register is free.
//  req_ready is low during that drain; the rsp output register holds the
//  word until taken. Reset (synchronous) empties the store and sets rank_k 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module streaming_kth_smallest_selector #(
   parameter int MAX_RANK   = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input words
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [VALUE_BITS-1:0]          req_sample_value,
   input  logic                                  req_last_item,
   // results
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [VALUE_BITS-1:0]          rsp_kth_value,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sks_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [sks_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [sks_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);
   import sks_pkg::*;

   localparam int CW = $clog2(MAX_RANK + 1);
   localparam int KW = (CW > RANK_BITS) ? CW : RANK_BITS;

   // ---------------- register port ----------------
   logic [RANK_BITS-1:0] rank_ff, rank_in;
   logic                 csr_hit;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_BITS-1] == CSR_IDX_RANK_K);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? CSR_DATA_BITS'(rank_ff) : '0;
   assign rank_in    = (csr_wr && csr_hit) ? csr_pwdata[RANK_BITS-1:0] : rank_ff;

   // ---------------- control ----------------
   sel_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, count_after;
   logic [KW-1:0] rank_ext, max_ext, k_eff;
   logic          full;
   logic          drop;
   logic          req_fire;
   logic          emit;
   logic          rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   cell_ctrl_type ctrl;

   logic signed [VALUE_BITS-1:0] cell_value [MAX_RANK+1];
   logic [MAX_RANK:0]            cell_valid;
   logic [MAX_RANK-1:0]          cell_gt;
   logic [MAX_RANK-1:0]          valid_vec;

   assign valid_vec = cell_valid[MAX_RANK-1:0];

   assign req_ready = (state_ff == ST_ACCEPT);
   assign req_fire  = req_valid && req_ready;

   assign full        = (count_ff == CW'(MAX_RANK));
   assign count_after = full ? count_ff : count_ff + 1'b1;

   // rank of zero reads as one, above the depth as the depth
   assign rank_ext = KW'(rank_ff);
   assign max_ext  = KW'(MAX_RANK);
   always_comb begin
      if (rank_ff == '0) begin
         k_eff = KW'(1);
      end else if (rank_ext > max_ext) begin
         k_eff = max_ext;
      end else begin
         k_eff = rank_ext;
      end
   end

   assign drop = (KW'(count_after) > k_eff);

   // result goes out once only cell 0 holds a word and the rsp register is free
   assign emit = (state_ff == ST_DRAIN) && !cell_valid[1] && (!rsp_valid_ff || rsp_ready);

   assign ctrl.load  = req_fire;
   assign ctrl.drop  = drop;
   assign ctrl.drain = (state_ff == ST_DRAIN) && cell_valid[1];
   assign ctrl.clear = emit;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCEPT: begin
            if (req_fire && req_last_item) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (emit) begin
               state_in = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (req_fire) begin
         if (req_last_item) begin
            count_in = '0;
         end else if (drop) begin
            count_in = count_after - 1'b1;
         end else begin
            count_in = count_after;
         end
      end
   end

   assign rsp_valid_in  = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_value_in  = emit ? cell_value[0] : rsp_value_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kth_value = rsp_value_ff;

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         count_ff     <= '0;
         rank_ff      <= RANK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- cell chain ----------------
   assign cell_value[MAX_RANK] = '0;
   assign cell_valid[MAX_RANK] = 1'b0;

   for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
      logic signed [VALUE_BITS-1:0] left_value;
      logic                         left_valid;
      logic                         left_gt;
      logic                         after_right;

      if (i == 0) begin : g_head
         assign left_value = req_sample_value;
         assign left_valid = 1'b1;
         assign left_gt    = 1'b0;
      end else begin : g_body
         assign left_value = cell_value[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      // the slot above this one is occupied after an insert iff this one was
      if (i == MAX_RANK - 1) begin : g_top
         assign after_right = 1'b0;
      end else begin : g_mid
         assign after_right = cell_valid[i];
      end

      sks_cell #(
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .sample_value (req_sample_value),
         .left_value   (left_value),
         .left_valid   (left_valid),
         .left_gt      (left_gt),
         .right_value  (cell_value[i+1]),
         .right_valid  (cell_valid[i+1]),
         .after_right  (after_right),
         .value        (cell_value[i]),
         .valid        (cell_valid[i]),
         .gt           (cell_gt[i])
      );
   end

   // ---------------- checks ----------------
   `SKS_ASSERT(a_valid_packed, clock, reset,
      ((valid_vec + 1'b1) & valid_vec) == '0,
      "store occupancy has a hole")
   `SKS_ASSERT(a_count_match, clock, reset,
      (state_ff == ST_ACCEPT) |-> ($countones(valid_vec) == count_ff),
      "kept count disagrees with cell valid bits")
   `SKS_ASSERT(a_last_drains, clock, reset,
      (req_fire && req_last_item) |=> (state_ff == ST_DRAIN && count_ff == '0),
      "last word did not start a drain")
   `SKS_ASSERT(a_emit_empties, clock, reset,
      emit |=> (valid_vec == '0 && rsp_valid_ff),
      "store not emptied after result")
   `SKS_ASSERT_NEVER(a_load_in_drain, clock, reset,
      ctrl.load && (ctrl.drain || ctrl.clear),
      "insert overlaps drain")

endmodule
